// ===== design/lbs_pkg.sv =====
// lbs_pkg: shared types and constants for the linear blend skinning block.
// No dependencies; every other design file refers to it by scoped names.

package lbs_pkg;

  // Bone count of the matrix store; each bone owns a 16-word slot, 12 used.
  localparam int MAX_BONES = 64;
  localparam int MAT_WORDS = 12;
  localparam int SLOT_WORDS = 16;
  localparam int MEM_DEPTH = MAX_BONES * SLOT_WORDS;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // Datapath widths: floored m*v term, row sum, weighted contribution, accumulator.
  localparam int TERM_W = 48;
  localparam int ROW_W = 50;
  localparam int CON_W = 52;
  localparam int ACC_W = 64;

  // Item action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CONTRIB = 1'b1;

  // Matrix column codes (row-major word index, low two bits).
  localparam logic [1:0] COL_X = 2'd0;
  localparam logic [1:0] COL_Y = 2'd1;
  localparam logic [1:0] COL_Z = 2'd2;
  localparam logic [1:0] COL_T = 2'd3;

  localparam logic [3:0] LAST_WORD = 4'(MAT_WORDS - 1);

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic action;
    logic [5:0] bone_index;
    logic [3:0] word_index;
    logic signed [31:0] matrix_word;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0] weight;
    logic direction_only;
    logic last_bone;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_t;

  // Tag that travels down the datapath with each matrix word read.
  typedef struct packed {
    logic vld;
    logic [1:0] row;
    logic [1:0] col;
  } issue_t;

endpackage

// ===== design/lbs_matrix_ram.sv =====
// lbs_matrix_ram: bone matrix store, one write and one registered read port.
// Depends on lbs_pkg for depth and address type.

module lbs_matrix_ram (
  input  logic                clk,
  input  logic                we,
  input  lbs_pkg::addr_t      waddr,
  input  logic signed [31:0]  wdata,
  input  logic                re,
  input  lbs_pkg::addr_t      raddr,
  output logic signed [31:0]  rdata
);

  logic signed [31:0] mem [lbs_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lbs_datapath.sv =====
// lbs_datapath: term multiply, row sum, weight multiply, saturating accumulate.
// Depends on lbs_pkg; fed by the registered read data of lbs_matrix_ram.

module lbs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lbs_pkg::issue_t     issue,
  input  logic signed [31:0]  rdata,
  input  lbs_pkg::in_t        op,
  input  logic                clear,
  output logic                busy,
  output lbs_pkg::out_t       sums
);

  lbs_pkg::issue_t tag1, tag2, tag3, tag4;

  logic signed [31:0]                  vsel;
  logic signed [63:0]                  prod;
  logic signed [lbs_pkg::TERM_W-1:0]   term_next;
  logic signed [lbs_pkg::TERM_W-1:0]   term;
  logic signed [lbs_pkg::ROW_W-1:0]    term_ext;
  logic signed [lbs_pkg::ROW_W-1:0]    row_sum;
  logic signed [lbs_pkg::ROW_W+17:0]   wfull;
  logic signed [lbs_pkg::CON_W-1:0]    contrib;
  logic signed [lbs_pkg::ACC_W-1:0]    acc [3];
  logic signed [lbs_pkg::ACC_W:0]      acc_sum;
  logic signed [lbs_pkg::ACC_W-1:0]    acc_next;

  function automatic logic signed [31:0] sat32(input logic signed [lbs_pkg::ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > lbs_pkg::ACC_W'(64'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -lbs_pkg::ACC_W'(64'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Stage 2: one 32x32 product per word, floored to Q16.16; translation passes, zeroed if direction_only.
  always_comb begin
    case (tag1.col)
      lbs_pkg::COL_X: vsel = op.pos_x;
      lbs_pkg::COL_Y: vsel = op.pos_y;
      lbs_pkg::COL_Z: vsel = op.pos_z;
      default:        vsel = '0;
    endcase
    prod = rdata * vsel;
    if (tag1.col == lbs_pkg::COL_T) begin
      term_next = op.direction_only ? '0
                : {{(lbs_pkg::TERM_W-32){rdata[31]}}, rdata};
    end else begin
      term_next = prod[63:16];
    end
  end

  assign term_ext = {{(lbs_pkg::ROW_W-lbs_pkg::TERM_W){term[lbs_pkg::TERM_W-1]}}, term};

  // Stage 4: floor(r * w / 65536) exactly.
  assign wfull = row_sum * $signed({1'b0, op.weight});

  // Stage 5: 65-bit sum, clamp on signed overflow.
  always_comb begin
    acc_sum = {acc[tag4.row][lbs_pkg::ACC_W-1], acc[tag4.row]}
            + {{(lbs_pkg::ACC_W+1-lbs_pkg::CON_W){contrib[lbs_pkg::CON_W-1]}}, contrib};
    if (acc_sum[lbs_pkg::ACC_W] != acc_sum[lbs_pkg::ACC_W-1]) begin
      acc_next = acc_sum[lbs_pkg::ACC_W] ? {1'b1, {(lbs_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(lbs_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_next = acc_sum[lbs_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
    end else begin
      tag1 <= issue;
      tag2 <= tag1;
      tag3.vld <= tag2.vld && (tag2.col == lbs_pkg::COL_T);
      tag3.row <= tag2.row;
      tag3.col <= tag2.col;
      tag4 <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    if (tag1.vld) begin
      term <= term_next;
    end
    if (tag2.vld) begin
      row_sum <= (tag2.col == lbs_pkg::COL_X) ? term_ext : row_sum + term_ext;
    end
    if (tag3.vld) begin
      contrib <= wfull[lbs_pkg::ROW_W+17:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc[0] <= '0;
      acc[1] <= '0;
      acc[2] <= '0;
    end else if (tag4.vld) begin
      acc[tag4.row] <= acc_next;
    end
  end

  assign busy = tag1.vld | tag2.vld | tag3.vld | tag4.vld;

  assign sums.out_x = sat32(acc[0]);
  assign sums.out_y = sat32(acc[1]);
  assign sums.out_z = sat32(acc[2]);

endmodule

// ===== design/linear_blend_vertex_skinning_top.sv =====
// linear_blend_vertex_skinning_top: sequencer, matrix store and output register.
// Depends on lbs_pkg, lbs_matrix_ram and lbs_datapath.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------
//   item     | in        | item_valid / item_stall   | lbs_pkg::in_t
//   result   | out       | result_valid / result_stall | lbs_pkg::out_t
//
// Matrix write: the word goes straight into the store.
// Contribution: accept, then 12 store reads (one word per cycle, one read port);
//   the last word passes the datapath stages to its accumulator, and a pair
//   marked last then hands off its result. item_stall stays high until the
//   block is idle again, so a new pair is taken only once the last is through.
// A pair whose bone is out of range skips the reads; only one marked last stalls.
// rst (synchronous) clears the accumulators, pipe tags and result_valid;
//   the matrix store is not cleared.
// A stalled result holds; a new item is still taken behind it, and only a
//   pair marked last waits until the output register is free.

module linear_blend_vertex_skinning_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  lbs_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output lbs_pkg::out_t result
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN
  } state_t;

  state_t          state;
  lbs_pkg::in_t    cur;        // latched contribution
  logic [3:0]      word_cnt;   // matrix word being read, row-major

  logic            take;
  logic            bone_ok;
  logic            wr_en;
  logic            rd_en;
  lbs_pkg::addr_t  wr_addr;
  lbs_pkg::addr_t  rd_addr;
  logic signed [31:0] rd_data;
  lbs_pkg::issue_t issue;
  logic            busy;
  logic            slot_free;
  logic            emit;
  logic            acc_clear;
  lbs_pkg::out_t   sums;

  assign item_stall = (state != IDLE);
  assign take       = item_valid && !item_stall;
  assign bone_ok    = int'(item.bone_index) < lbs_pkg::MAX_BONES;

  // Writes only happen while idle, reads only while running: no overlap on
  // the store, so no forwarding is needed.
  assign wr_en   = take && (item.action == lbs_pkg::ACT_WRITE) && bone_ok
                && (int'(item.word_index) < lbs_pkg::MAT_WORDS);
  assign wr_addr = lbs_pkg::addr_t'({item.bone_index, item.word_index});
  assign rd_en   = (state == RUN);
  assign rd_addr = lbs_pkg::addr_t'({cur.bone_index, word_cnt});

  assign issue.vld = rd_en;
  assign issue.row = word_cnt[3:2];
  assign issue.col = word_cnt[1:0];

  // Result hand-off once the pipe is empty; the output slot frees up in the
  // same cycle it is taken downstream.
  assign slot_free = !result_valid || !result_stall;
  assign emit      = (state == DRAIN) && !busy && cur.last_bone && slot_free;
  assign acc_clear = emit;

  lbs_matrix_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item.matrix_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lbs_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .rdata (rd_data),
    .op    (cur),
    .clear (acc_clear),
    .busy  (busy),
    .sums  (sums)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      word_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          word_cnt <= '0;
          if (take && (item.action == lbs_pkg::ACT_CONTRIB)) begin
            if (bone_ok) begin
              state <= RUN;
            end else if (item.last_bone) begin
              // out-of-range bone adds nothing but still closes the vertex
              state <= DRAIN;
            end
          end
        end
        RUN: begin
          word_cnt <= word_cnt + 4'd1;
          if (word_cnt == lbs_pkg::LAST_WORD) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          // a pair marked last leaves only together with its result
          if (!busy && (!cur.last_bone || slot_free)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= item;
    end
    if (emit) begin
      result <= sums;
    end
  end

endmodule

// ===== design/lbs_checker.sv =====
// lbs_checker: port-level assertions for linear_blend_vertex_skinning_top.
// Depends on lbs_pkg; bound to the top level at the end of this file.

module lbs_checker (
  input logic          clk,
  input logic          rst,
  input logic          item_valid,
  input logic          item_stall,
  input lbs_pkg::in_t  item,
  input logic          result_valid,
  input logic          result_stall,
  input lbs_pkg::out_t result
);

  logic take_wr;
  logic take_busy;

  assign take_wr   = item_valid && !item_stall && (item.action == lbs_pkg::ACT_WRITE);
  assign take_busy = item_valid && !item_stall && (item.action == lbs_pkg::ACT_CONTRIB)
                  && ((int'(item.bone_index) < lbs_pkg::MAX_BONES) || item.last_bone);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a matrix write never blocks the next item
  a_write_no_stall: assert property (@(posedge clk) disable iff (rst)
    take_wr |=> !item_stall)
    else $error("stall after matrix write");

  // a write transfer never creates a result
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    take_wr && !result_valid |=> !result_valid)
    else $error("result after matrix write");

  // a real contribution occupies the block in the next cycle
  a_contrib_busy: assert property (@(posedge clk) disable iff (rst)
    take_busy |=> item_stall)
    else $error("contribution did not occupy block");

  // results only appear out of a busy phase
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result without work in progress");

endmodule

bind linear_blend_vertex_skinning_top lbs_checker u_lbs_checker (.*);

// ===== verif/tb.sv =====
// tb: self-checking testbench for linear_blend_vertex_skinning_top.
// Depends on lbs_pkg for the item and result structs, the action codes and the store size.
// A class predicts the blended vertices; plain tasks drive matrix loads and bone pairs.
`timescale 1ns / 1ps

module tb;

  import lbs_pkg::*;

  // Wide signed math: r * weight can exceed 64 bits before the shift.
  typedef logic signed [127:0] wide_t;

  localparam wide_t  I64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam wide_t  I64_MIN = -I64_MAX - 1;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int     STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int     ITEM_TARGET = 950;
  localparam int     CALM_AFTER = 860;    // from here on, no idling on either side
  localparam int     DRAIN_CYCLES = 40;   // extra wait after the last owed vertex is checked

  // Blend predictor: own copy of the matrix store and the three accumulators,
  // plus the queue of vertices still owed by the block.
  class skin_predictor;
    logic signed [31:0] mat [MAX_BONES][MAT_WORDS];
    longint             acc [3];
    out_t               owed_vertices [$];
    int                 errors;

    function new();
      errors = 0;
      foreach (acc[i]) acc[i] = 0;
    endfunction

    // weight * (row . [x y z 1|0]), each product floored to Q16.16 first
    function wide_t row_gain(int bone, int row, in_t it);
      wide_t x, y, z, w, r, m0, m1, m2, mt;
      x = it.pos_x;
      y = it.pos_y;
      z = it.pos_z;
      w = it.weight;
      m0 = mat[bone][row*4 + COL_X];
      m1 = mat[bone][row*4 + COL_Y];
      m2 = mat[bone][row*4 + COL_Z];
      mt = mat[bone][row*4 + COL_T];
      r = ((m0 * x) >>> 16) + ((m1 * y) >>> 16) + ((m2 * z) >>> 16);
      if (!it.direction_only) r = r + mt;
      return (r * w) >>> 16;
    endfunction

    function longint sat64(wide_t v);
      if (v > I64_MAX) v = I64_MAX;
      if (v < I64_MIN) v = I64_MIN;
      return longint'(v[63:0]);
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > I32_MAX) v = I32_MAX;
      if (v < I32_MIN) v = I32_MIN;
      return v[31:0];
    endfunction

    // Called for every accepted item transfer.
    function void absorb_item(in_t it);
      wide_t a;
      out_t  vtx;
      if (it.action == ACT_WRITE) begin
        if (it.word_index <= LAST_WORD && int'(it.bone_index) < MAX_BONES)
          mat[it.bone_index][it.word_index] = it.matrix_word;
      end else begin
        if (int'(it.bone_index) < MAX_BONES) begin
          for (int row = 0; row < 3; row++) begin
            a = acc[row];
            acc[row] = sat64(a + row_gain(it.bone_index, row, it));
          end
        end
        if (it.last_bone) begin
          vtx.out_x = clip32(acc[0]);
          vtx.out_y = clip32(acc[1]);
          vtx.out_z = clip32(acc[2]);
          owed_vertices.push_back(vtx);
          foreach (acc[i]) acc[i] = 0;
        end
      end
    endfunction

    // Called for every accepted result transfer.
    function void check_vertex(out_t got);
      out_t              want;
      logic signed [31:0] g [3];
      logic signed [31:0] e [3];
      string             axis;
      axis = "xyz";
      if (owed_vertices.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 got.out_x, got.out_y, got.out_z);
        errors++;
      end else begin
        want = owed_vertices.pop_front();
        g = '{got.out_x, got.out_y, got.out_z};
        e = '{want.out_x, want.out_y, want.out_z};
        for (int k = 0; k < 3; k++) begin
          if (g[k] !== e[k]) begin
            $display("%0t: out_%c expected %0d actual %0d", $time, axis[k], e[k], g[k]);
            errors++;
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_t  item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  skin_predictor board = new();

  // Stimulus-side bookkeeping: which words were loaded, so no pair ever
  // reads a matrix entry that was never written.
  bit written [MAX_BONES][MAT_WORDS];
  bit is_ready [MAX_BONES];
  int ready_bones [$];
  int items_sent = 0;
  bit calm = 1'b0;

  linear_blend_vertex_skinning_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor: outputs are sampled right after the edge, before any update
  // of that edge lands, so each transfer is seen with the pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) board.check_vertex(result);
      if (item_valid && !item_stall) board.absorb_item(item);
    end
  end

  // Result side back-pressure: random stall bursts, none in the calm tail.
  initial begin : result_pacer
    forever begin
      if (calm || $urandom_range(0, 3) != 0) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run if nothing transfers for too long.
  initial begin : watchdog
    int still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) still = 0;
      else still++;
    end
    $display("FAILURE");
    $finish;
  end

  // One item transfer; payload and valid hold until the block takes it.
  // An optional idle burst goes before it.
  task automatic send_item(input in_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // Small Q16.16 values so sums stay in range, mixed with extremes, zero and full-range words.
  function automatic logic signed [31:0] rand_q16();
    int s;
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3, 4: return $urandom;
      default: begin
        s = $urandom_range(0, 524287);
        return s - 262144;
      end
    endcase
  endfunction

  // Matrix word load; the fields a load ignores carry junk.
  task automatic write_word(input int bone, input int word, input logic signed [31:0] value);
    in_t it;
    bit  full;
    it.action         = ACT_WRITE;
    it.bone_index     = 6'(bone);
    it.word_index     = 4'(word);
    it.matrix_word    = value;
    it.pos_x          = $urandom;
    it.pos_y          = $urandom;
    it.pos_z          = $urandom;
    it.weight         = 17'($urandom_range(0, 131071));
    it.direction_only = 1'($urandom_range(0, 1));
    it.last_bone      = 1'($urandom_range(0, 1));
    send_item(it);
    items_sent++;
    if (word < MAT_WORDS) begin
      written[bone][word] = 1'b1;
      full = 1'b1;
      for (int k = 0; k < MAT_WORDS; k++) full &= written[bone][k];
      if (full && !is_ready[bone]) begin
        is_ready[bone] = 1'b1;
        ready_bones.push_back(bone);
      end
    end
  endtask

  // One vertex-bone pair; matrix_word and word_index are junk here.
  task automatic add_pair(input int bone, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] z,
                          input int wgt, input bit dir, input bit last);
    in_t it;
    it.action         = ACT_CONTRIB;
    it.bone_index     = 6'(bone);
    it.word_index     = 4'($urandom_range(0, 15));
    it.matrix_word    = $urandom;
    it.pos_x          = x;
    it.pos_y          = y;
    it.pos_z          = z;
    it.weight         = 17'(wgt);
    it.direction_only = dir;
    it.last_bone      = last;
    send_item(it);
    items_sent++;
  endtask

  task automatic load_matrix(input int bone);
    for (int w = 0; w < MAT_WORDS; w++) write_word(bone, w, rand_q16());
  endtask

  initial begin : stimulus
    int npairs;
    int bone;
    int wgt;
    bit dir;
    logic signed [31:0] q_one;
    logic signed [31:0] q_max;
    logic signed [31:0] q_min;
    q_one = 32'sh0001_0000;
    q_max = 32'sh7FFF_FFFF;
    q_min = 32'sh8000_0000;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Bone 0 matrix with extreme entries in every column.
    write_word(0, 0, q_max);
    write_word(0, 1, q_min);
    write_word(0, 2, q_one);
    write_word(0, 3, q_max);
    write_word(0, 4, -q_one);
    write_word(0, 5, 32'sh0);
    write_word(0, 6, q_min);
    write_word(0, 7, q_min);
    write_word(0, 8, 32'sh0001_2345);
    write_word(0, 9, 32'shFFFF_0000);
    write_word(0, 10, q_max);
    write_word(0, 11, 32'sh0000_0001);
    // Word index past the matrix: load must be dropped.
    write_word(0, 15, 32'shFFFF_FFFF);
    // Full-scale vector, unit weight: outputs clip.
    add_pair(0, q_max, q_max, q_max, 65536, 1'b0, 1'b1);
    // Two pairs, one with translation and one without, max weight.
    add_pair(0, q_min, q_min, q_min, 131071, 1'b0, 1'b0);
    add_pair(0, q_min, q_min, q_min, 131071, 1'b1, 1'b1);
    // Vertex with no bones: single zero-weight pair.
    add_pair(0, $urandom, $urandom, $urandom, 0, 1'b0, 1'b1);
    // Tiny values to exercise floor rounding of negative terms.
    add_pair(0, 32'sh1, -32'sh1, 32'sh0, 1, 1'b0, 1'b1);
    // A load in the middle of a vertex keeps the partial sums.
    add_pair(0, q_one, -q_one, q_one, 32768, 1'b0, 1'b0);
    write_word(63, 0, q_max);
    add_pair(0, q_one, q_one, -q_one, 32768, 1'b1, 1'b1);

    // ---- random part ----
    load_matrix(63);
    repeat (3) load_matrix($urandom_range(1, 62));

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > CALM_AFTER) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: load_matrix($urandom_range(0, 63));
        1: begin
          // scattered loads, some past the last word
          repeat ($urandom_range(1, 3))
            write_word($urandom_range(0, 63), $urandom_range(0, 15), rand_q16());
        end
        default: begin
          // one well-formed vertex of 1..4 bone pairs
          npairs = $urandom_range(1, 4);
          dir = ($urandom_range(0, 3) == 0);
          for (int p = 0; p < npairs; p++) begin
            bone = ready_bones[$urandom_range(0, ready_bones.size() - 1)];
            case ($urandom_range(0, 5))
              0: wgt = 0;
              1: wgt = 65536;
              2: wgt = $urandom_range(0, 131071);
              default: wgt = $urandom_range(0, 65536 / npairs);
            endcase
            if ($urandom_range(0, 15) == 0)
              write_word($urandom_range(0, 63), $urandom_range(0, 15), rand_q16());
            add_pair(bone, rand_q16(), rand_q16(), rand_q16(), wgt, dir, p == npairs - 1);
          end
        end
      endcase
    end

    // ---- drain ----
    item_valid <= 1'b0;
    while (board.owed_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.owed_vertices.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lbs_pkg.sv
design/lbs_matrix_ram.sv
design/lbs_datapath.sv
design/linear_blend_vertex_skinning_top.sv
design/lbs_checker.sv
verif/tb.sv
